// File: design/calorimeter_channel_accumulator_macros.svh
// assertion macros shared by the calorimeter channel accumulator
`ifndef CALORIMETER_CHANNEL_ACCUMULATOR_MACROS_SVH
`define CALORIMETER_CHANNEL_ACCUMULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition must never hold outside reset
`define CCA_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cca assertion failed");
// antecedent implies consequent in the same cycle
`define CCA_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cca assertion failed");
// antecedent implies consequent in the next cycle
`define CCA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cca assertion failed");
`else
`define CCA_ASSERT_NEVER(label, clk, rst, expr)
`define CCA_ASSERT_IMPLIES(label, clk, rst, a, b)
`define CCA_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: design/cca_pkg.sv
// types, constants and codes shared by the channel accumulator modules
`timescale 1ns / 1ps
package cca_pkg;

  // field widths
  localparam int CHAN_W  = 14;
  localparam int E_W     = 32;
  localparam int SUM_W   = 40;
  localparam int EVT_W   = 32;
  localparam int DET_W   = 5;   // copy/1000 for a 14 bit copy number
  localparam int LYR_W   = 10;  // copy mod 1000

  // copy number decode: detector = copy / 1000 by reciprocal multiply
  localparam int COPY_STRIDE = 1000;
  localparam int RECIP_W     = 15;
  localparam int RECIP       = 16778;  // ceil(2^24 / 1000), exact for copy < 2^14
  localparam int RECIP_SHIFT = 24;

  // parameter defaults
  localparam int DEF_LAYERS    = 100;
  localparam int DEF_DETECTORS = 3;

  // result kinds
  localparam logic [2:0] EMIT_NONE  = 3'd0;
  localparam logic [2:0] EMIT_BAD   = 3'd1;
  localparam logic [2:0] EMIT_EMPTY = 3'd2;
  localparam logic [2:0] EMIT_LAST  = 3'd3;
  localparam logic [2:0] EMIT_MORE  = 3'd4;

  typedef struct packed {
    logic              action;
    logic [CHAN_W-1:0] copy_number;
    logic [E_W-1:0]    deposit_energy;
  } cca_item_t;

  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] channel_number;
    logic [SUM_W-1:0]  energy_sum;
    logic [EVT_W-1:0]  event_number;
    logic              last;
    logic              bad_channel;
  } cca_result_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       dec;
    logic       dep_rd;
    logic       dep_wr;
    logic       clr_step;
    logic       scan_start;
    logic       scan_step;
    logic       hit;
    logic [2:0] emit;
  } cca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_action;
    logic in_zero;
    logic clr_last;
    logic bad;
    logic chk_vld;
    logic data_nz;
  } cca_stat_t;

endpackage

// File: design/cca_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cca_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 300,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/cca_ctrl.sv
// controller state machine for the channel accumulator
`timescale 1ns / 1ps
module cca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cca_pkg::cca_stat_t stat,
  output cca_pkg::cca_cmd_t  cmd,
  output logic               busy
);
  import cca_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_SCAN1 = 3'd5;
  localparam logic [2:0] S_SCAN2 = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register, clearing pass runs first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (stat.in_action) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN1;
          end else if (!stat.in_zero) begin
            cmd.load_in = 1'b1;
            state_next  = S_DEC;
          end
        end
      end
      S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (stat.bad) begin
          cmd.emit   = EMIT_BAD;
          state_next = S_IDLE;
        end else begin
          cmd.dep_rd = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.dep_wr = 1'b1;
        state_next = S_IDLE;
      end
      // look for the next nonzero bin
      S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (!stat.chk_vld) begin
          cmd.emit   = EMIT_EMPTY;
          state_next = S_IDLE;
        end else if (stat.data_nz) begin
          cmd.hit    = 1'b1;
          state_next = S_SCAN2;
        end
      end
      // look past the hit to decide last
      S_SCAN2: begin
        cmd.scan_step = 1'b1;
        if (!stat.chk_vld) begin
          cmd.emit   = EMIT_LAST;
          state_next = S_IDLE;
        end else if (stat.data_nz) begin
          cmd.emit   = EMIT_MORE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: design/cca_dp.sv
// datapath: copy number decode, bin memory, readout scan and result register
`timescale 1ns / 1ps
module cca_dp #(
  parameter int LAYERS_PER_DETECTOR = cca_pkg::DEF_LAYERS,
  parameter int NUM_DETECTORS       = cca_pkg::DEF_DETECTORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cca_pkg::cca_item_t   item,
  input  cca_pkg::cca_cmd_t    cmd,
  output cca_pkg::cca_stat_t   stat,
  output logic                 result_valid,
  output cca_pkg::cca_result_t result
);
  import cca_pkg::*;

  localparam int BINS = NUM_DETECTORS * LAYERS_PER_DETECTOR;
  localparam int AW   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int IW   = $clog2(BINS + 1);
  localparam int SDW  = $clog2(NUM_DETECTORS + 2);
  localparam int PW   = CHAN_W + RECIP_W;

  // deposit registers
  logic [CHAN_W-1:0] copy_q;
  logic [E_W-1:0]    energy_q;
  logic [DET_W-1:0]  det_q;
  logic [LYR_W-1:0]  layer_q;
  logic              bad_q;
  logic [AW-1:0]     bin_q;

  // scan registers
  logic [IW-1:0]    ptr_idx, iss_idx, chk_idx, nxt_idx;
  logic [SDW-1:0]   ptr_det, iss_det, chk_det, nxt_det, hit_det;
  logic [LYR_W-1:0] ptr_lyr, iss_lyr, chk_lyr, nxt_lyr, hit_lyr;
  logic             chk_vld;
  logic [SUM_W-1:0] hit_sum;
  logic [EVT_W-1:0] evt;
  logic [AW-1:0]    clr_addr;

  // memory ports
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [SUM_W-1:0] wdata, rdata;

  // combinational helpers
  logic [PW-1:0]     prod;
  logic [CHAN_W-1:0] lyr_full;
  logic [IW-1:0]     bin_full;
  logic [SUM_W:0]    acc;
  logic [SUM_W-1:0]  sat;
  logic [IW-1:0]     src_idx, inc_idx;
  logic [SDW-1:0]    src_det, inc_det;
  logic [LYR_W-1:0]  src_lyr, inc_lyr;
  logic              src_in, lyr_wrap;
  logic [CHAN_W-1:0] hit_chan;

  // detector = copy / 1000 by reciprocal
  assign prod = PW'(item.copy_number) * PW'(RECIP);
  // layer = copy - detector * 1000
  assign lyr_full = copy_q - CHAN_W'(det_q) * CHAN_W'(COPY_STRIDE);
  // linear bin index
  assign bin_full = IW'(det_q - DET_W'(1)) * IW'(LAYERS_PER_DETECTOR) + IW'(layer_q);
  // saturating accumulate
  assign acc = {1'b0, rdata} + (SUM_W + 1)'(energy_q);
  assign sat = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];

  // scan source: stored pointer at start, issue counter while stepping
  assign src_idx  = cmd.scan_start ? ptr_idx : iss_idx;
  assign src_det  = cmd.scan_start ? ptr_det : iss_det;
  assign src_lyr  = cmd.scan_start ? ptr_lyr : iss_lyr;
  assign src_in   = (src_idx < IW'(BINS));
  assign lyr_wrap = (src_lyr == LYR_W'(LAYERS_PER_DETECTOR - 1));
  assign inc_idx  = src_idx + IW'(1);
  assign inc_lyr  = lyr_wrap ? '0 : src_lyr + LYR_W'(1);
  assign inc_det  = lyr_wrap ? src_det + SDW'(1) : src_det;

  assign hit_chan = CHAN_W'(hit_det) * CHAN_W'(COPY_STRIDE) + CHAN_W'(hit_lyr);

  // memory read port
  assign re    = cmd.dep_rd | ((cmd.scan_start | cmd.scan_step) & src_in);
  assign raddr = cmd.dep_rd ? bin_full[AW-1:0] : src_idx[AW-1:0];

  // memory write port: clearing pass, deposit update, clear on readout
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.dep_wr) begin
      we    = 1'b1;
      waddr = bin_q;
      wdata = sat;
    end else if (cmd.hit) begin
      we    = 1'b1;
      waddr = chk_idx[AW-1:0];
    end
  end

  cca_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BINS),
    .AW    (AW)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status
  assign stat.in_action = item.action;
  assign stat.in_zero   = (item.deposit_energy == '0);
  assign stat.clr_last  = (clr_addr == AW'(BINS - 1));
  assign stat.bad       = bad_q;
  assign stat.chk_vld   = chk_vld;
  assign stat.data_nz   = (rdata != '0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      ptr_idx      <= '0;
      ptr_det      <= SDW'(1);
      ptr_lyr      <= '0;
      evt          <= EVT_W'(1);
      chk_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != EMIT_NONE);
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.scan_start || cmd.scan_step) begin
        chk_vld <= src_in;
      end
      // scan end returns the pointer and moves to the next event
      if (cmd.emit == EMIT_EMPTY || cmd.emit == EMIT_LAST) begin
        ptr_idx <= '0;
        ptr_det <= SDW'(1);
        ptr_lyr <= '0;
        evt     <= evt + EVT_W'(1);
      end else if (cmd.emit == EMIT_MORE) begin
        ptr_idx <= nxt_idx;
        ptr_det <= nxt_det;
        ptr_lyr <= nxt_lyr;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      copy_q   <= item.copy_number;
      energy_q <= item.deposit_energy;
      det_q    <= prod[RECIP_SHIFT +: DET_W];
    end
    if (cmd.dec) begin
      layer_q <= lyr_full[LYR_W-1:0];
      bad_q   <= (det_q == '0) || (det_q > DET_W'(NUM_DETECTORS)) ||
                 (lyr_full >= CHAN_W'(LAYERS_PER_DETECTOR));
    end
    if (cmd.dep_rd) begin
      bin_q <= bin_full[AW-1:0];
    end
    // issue and check stages of the scan stream
    if (cmd.scan_start || cmd.scan_step) begin
      chk_idx <= src_idx;
      chk_det <= src_det;
      chk_lyr <= src_lyr;
      if (src_in) begin
        iss_idx <= inc_idx;
        iss_det <= inc_det;
        iss_lyr <= inc_lyr;
      end else begin
        iss_idx <= src_idx;
        iss_det <= src_det;
        iss_lyr <= src_lyr;
      end
    end
    // capture the reported bin and the position just beyond it
    if (cmd.hit) begin
      hit_det <= chk_det;
      hit_lyr <= chk_lyr;
      hit_sum <= rdata;
      nxt_idx <= iss_idx;
      nxt_det <= iss_det;
      nxt_lyr <= iss_lyr;
    end
    // result register
    case (cmd.emit)
      EMIT_BAD: begin
        result.found          <= 1'b0;
        result.channel_number <= copy_q;
        result.energy_sum     <= '0;
        result.event_number   <= evt;
        result.last           <= 1'b0;
        result.bad_channel    <= 1'b1;
      end
      EMIT_EMPTY: begin
        result.found          <= 1'b0;
        result.channel_number <= '0;
        result.energy_sum     <= '0;
        result.event_number   <= evt;
        result.last           <= 1'b1;
        result.bad_channel    <= 1'b0;
      end
      EMIT_LAST, EMIT_MORE: begin
        result.found          <= 1'b1;
        result.channel_number <= hit_chan;
        result.energy_sum     <= hit_sum;
        result.event_number   <= evt;
        result.last           <= (cmd.emit == EMIT_LAST);
        result.bad_channel    <= 1'b0;
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

// File: design/calorimeter_channel_accumulator.sv
// top level of the calorimeter channel accumulator
`timescale 1ns / 1ps
`include "calorimeter_channel_accumulator_macros.svh"
// Per-channel energy accumulator with zero-suppressed readout.
// Input channel: an item is taken when start is high and busy is low.
//   action 0 adds deposit_energy (eV) to the bin of copy_number; action 1
//   is one readout step that reports and clears the next nonzero bin.
// Result channel: result is valid for exactly one cycle with result_valid;
//   the receiver cannot stall, so nothing is held back.
// Handling by item kind:
//   zero deposit: no result, busy stays low
//   good deposit: busy through the decode, read and write states, no result
//   bad copy number: busy through decode and read, then a bad_channel result
//   readout: busy while one bin is read per cycle from the scan pointer
//   through the next nonzero bin after the reported one (or to the end),
//   then the result is registered.
// The bin memory takes one read and one write a cycle, with registered read.
// Reset: synchronous rst starts a clearing pass over all
//   NUM_DETECTORS*LAYERS_PER_DETECTOR bins (300 by default), one bin a
//   cycle, with busy high; the scan pointer returns to the first bin, the
//   event number to 1.
module calorimeter_channel_accumulator #(
  parameter int LAYERS_PER_DETECTOR = cca_pkg::DEF_LAYERS,
  parameter int NUM_DETECTORS       = cca_pkg::DEF_DETECTORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cca_pkg::cca_item_t   item,
  output logic                 busy,
  output logic                 result_valid,
  output cca_pkg::cca_result_t result
);
  import cca_pkg::*;

  cca_cmd_t  cmd;
  cca_stat_t stat;

  // sequencer
  cca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // bins, decode and scan
  cca_dp #(
    .LAYERS_PER_DETECTOR (LAYERS_PER_DETECTOR),
    .NUM_DETECTORS       (NUM_DETECTORS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

  // checks
  `CCA_ASSERT_NEVER(a_bad_not_last, clk, rst, result_valid && result.last && result.bad_channel)
  `CCA_ASSERT_IMPLIES(a_found_nonzero, clk, rst, result_valid && result.found, result.energy_sum != '0)
  `CCA_ASSERT_IMPLIES(a_bad_empty, clk, rst, result_valid && result.bad_channel, !result.found && (result.energy_sum == '0))
  `CCA_ASSERT_NEXT(a_readout_busy, clk, rst, start && !busy && item.action, busy)

endmodule

// File: verif/testbench.sv
// self-checking testbench for the calorimeter channel accumulator
`timescale 1ns / 1ps
module testbench;
  import cca_pkg::*;

  localparam int NUM_DET = DEF_DETECTORS;
  localparam int NUM_LYR = DEF_LAYERS;
  localparam int NUM_BINS = NUM_DET * NUM_LYR;
  localparam logic [SUM_W-1:0] SUM_FULL = '1;
  localparam logic ACT_DEPOSIT = 1'b0;
  localparam logic ACT_READOUT = 1'b1;
  localparam int SETTLE_CYCLES = NUM_BINS + 20;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 195;
  localparam int SAT_DEPOSITS = 257;
  localparam int REPORT_LIMIT = 10;

  // per-bin energy ledger: predicts readout beats and checks them in order
  class bin_ledger;
    logic [SUM_W-1:0] bin_energy [NUM_BINS];
    int unsigned      scan_at;
    logic [EVT_W-1:0] event_no;
    cca_result_t      pending_reports [$];
    int               mismatches;
    bit               scan_closed;

    function new();
      foreach (bin_energy[i]) bin_energy[i] = '0;
      scan_at = 0;
      event_no = 1;
      mismatches = 0;
      scan_closed = 1'b0;
    endfunction

    function int unsigned next_filled(int unsigned from);
      for (int unsigned i = from; i < NUM_BINS; i++)
        if (bin_energy[i] != '0) return i;
      return NUM_BINS;
    endfunction

    // update the bins for one accepted beat and queue the report it causes
    function void book_item(cca_item_t it);
      int unsigned det, lyr, idx;
      logic [SUM_W:0] total;
      cca_result_t r;
      r = '0;
      r.event_number = event_no;
      if (it.action == ACT_DEPOSIT) begin
        if (it.deposit_energy == '0) return;
        det = it.copy_number / COPY_STRIDE;
        lyr = it.copy_number % COPY_STRIDE;
        if (det < 1 || det > NUM_DET || lyr >= NUM_LYR) begin
          r.bad_channel = 1'b1;
          r.channel_number = it.copy_number;
          pending_reports.push_back(r);
        end else begin
          idx = (det - 1) * NUM_LYR + lyr;
          total = bin_energy[idx] + it.deposit_energy;
          bin_energy[idx] = total[SUM_W] ? SUM_FULL : total[SUM_W-1:0];
        end
      end else begin
        idx = next_filled(scan_at);
        if (idx < NUM_BINS) begin
          r.found = 1'b1;
          r.channel_number = CHAN_W'((idx / NUM_LYR + 1) * COPY_STRIDE + idx % NUM_LYR);
          r.energy_sum = bin_energy[idx];
          bin_energy[idx] = '0;
          r.last = (next_filled(idx + 1) >= NUM_BINS);
        end else begin
          r.last = 1'b1;
        end
        pending_reports.push_back(r);
        if (r.last) begin
          scan_at = 0;
          event_no = event_no + 1;
          scan_closed = 1'b1;
        end else begin
          scan_at = idx + 1;
        end
      end
    endfunction

    // compare one result beat with the oldest queued report
    function void match_readout(cca_result_t got);
      cca_result_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with none queued: chan %0d sum %0h event %0d",
                   $time, got.channel_number, got.energy_sum, got.event_number);
        return;
      end
      want = pending_reports.pop_front();
      if (want.found !== got.found || want.channel_number !== got.channel_number ||
          want.energy_sum !== got.energy_sum || want.event_number !== got.event_number ||
          want.last !== got.last || want.bad_channel !== got.bad_channel) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch (exp/got) found %0b/%0b chan %0d/%0d sum %0h/%0h",
                   $time, want.found, got.found, want.channel_number,
                   got.channel_number, want.energy_sum, got.energy_sum);
          $display("%0t:   event %0d/%0d last %0b/%0b bad %0b/%0b",
                   $time, want.event_number, got.event_number, want.last, got.last,
                   want.bad_channel, got.bad_channel);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  cca_item_t   item;
  logic        busy;
  logic        result_valid;
  cca_result_t result;

  bin_ledger   ledger;
  int          idle_pct;
  int          items_sent;
  int          cycle_count = 0;

  calorimeter_channel_accumulator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid) ledger.match_readout(result);
  end

  // present one beat and hold it until the block takes it
  task automatic put_item(logic act, logic [CHAN_W-1:0] copy, logic [E_W-1:0] energy);
    cca_item_t it;
    it.action = act;
    it.copy_number = copy;
    it.deposit_energy = energy;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    ledger.book_item(it);
    if (act == ACT_READOUT || energy != '0) items_sent++;
  endtask

  // hold off until every report is in and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [E_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return 1;
      2, 3: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  // a channel that decodes to a valid bin, edge layers favoured
  function automatic logic [CHAN_W-1:0] pick_channel();
    int unsigned lyr;
    if ($urandom_range(0, 5) == 0) lyr = $urandom_range(0, 1) ? NUM_LYR - 1 : 0;
    else lyr = $urandom_range(0, NUM_LYR - 1);
    return CHAN_W'($urandom_range(1, NUM_DET) * COPY_STRIDE + lyr);
  endfunction

  // readout step, the unused fields random
  task automatic read_step();
    put_item(ACT_READOUT, CHAN_W'($urandom_range(0, 16383)), $urandom);
  endtask

  // anything the fields allow, bad channels and zero energy included
  task automatic stray_item();
    logic [E_W-1:0] e;
    e = ($urandom_range(0, 3) == 0) ? '0 : pick_energy();
    put_item(logic'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, 16383)), e);
  endtask

  // deposits for one event, then readout either to the end or cut short
  task automatic run_event(int ndep, bit complete);
    repeat (ndep) begin
      if ($urandom_range(0, 9) == 0) stray_item();
      else put_item(ACT_DEPOSIT, pick_channel(), pick_energy());
    end
    ledger.scan_closed = 1'b0;
    if (complete) begin
      do begin
        if ($urandom_range(0, 6) == 0) put_item(ACT_DEPOSIT, pick_channel(), pick_energy());
        read_step();
      end while (!ledger.scan_closed);
    end else begin
      repeat ($urandom_range(1, 2)) read_step();
    end
  endtask

  task automatic run_phase(int pct, int goal);
    idle_pct = pct;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) stray_item();
        1: run_event($urandom_range(1, 6), 1'b0);
        2: read_step();
        default: run_event($urandom_range(1, 12), 1'b1);
      endcase
    end
    settle();
  endtask

  // stimulus
  initial begin
    ledger = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    idle_pct = 13;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // empty readout, ignored zero deposits
    read_step();
    put_item(ACT_DEPOSIT, 14'd16383, '0);
    put_item(ACT_DEPOSIT, 14'd1000, '0);
    // good channels, most at the corners of the bin range
    put_item(ACT_DEPOSIT, 14'd1000, '1);
    put_item(ACT_DEPOSIT, 14'd3099, 32'd1);
    put_item(ACT_DEPOSIT, 14'd2050, 32'd12345);
    put_item(ACT_DEPOSIT, 14'd1099, 32'h8000_0000);
    // bad channels: detector zero, detector too high, layer too high
    put_item(ACT_DEPOSIT, 14'd0, 32'd5);
    put_item(ACT_DEPOSIT, 14'd999, 32'd7);
    put_item(ACT_DEPOSIT, 14'd4000, 32'd1);
    put_item(ACT_DEPOSIT, 14'd1100, 32'd2);
    put_item(ACT_DEPOSIT, 14'd9999, 32'd3);
    put_item(ACT_DEPOSIT, 14'd16383, '1);
    // walk the scan to its end, then once more on an empty event
    repeat (5) read_step();
    // deposit behind the scan is held for the next event
    put_item(ACT_DEPOSIT, 14'd1005, 32'd3);
    put_item(ACT_DEPOSIT, 14'd3000, 32'd4);
    read_step();
    put_item(ACT_DEPOSIT, 14'd1001, 32'd9);
    repeat (3) read_step();
    settle();

    run_phase(13, items_sent + PHASE_ITEMS);

    // saturate one bin, then read it out
    idle_pct = 59;
    repeat (SAT_DEPOSITS) put_item(ACT_DEPOSIT, 14'd2042, '1);
    put_item(ACT_DEPOSIT, 14'd2042, 32'd5);
    run_event(2, 1'b1);
    run_phase(59, items_sent + PHASE_ITEMS);

    run_phase(0, items_sent + PHASE_ITEMS);

    if (ledger.mismatches == 0 && ledger.pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
